/* rtl/bdq_pkg.sv */
package bdq_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_LIST       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_BACK,
    CMD_PUSH_FRONT,
    CMD_POP_FRONT,
    CMD_POP_BACK,
    CMD_ROTATE
  } cmd_t;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [DATA_W-1:0] push_value;
  } request_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data_value;
    logic                     last_result;
  } result_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] push_value;
    logic signed [DATA_W-1:0] head_value;
  } cell_ctrl_t;

endpackage

/* rtl/bounded_deque.sv */
// Channel   Ports                       Direction  Beat taken when
// request   start, busy, request        in         start high and busy low
// result    strobe, result              out        strobe high
//
// The result of each push or pop appears on the cycle after it is taken.
// A list of N entries holds busy high while it runs and gives N results on consecutive cycles.
// The list length is set by the entry count, and the cell chain rotates one entry per cycle.
// Reset empties every cell and clears busy and strobe.
// The receiver cannot stall, so results are never held back.
module bounded_deque
  import bdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     strobe,
  output result_t  result
);

  logic signed [DATA_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]      cell_valid;
  logic [CAPACITY-1:0]      cell_tail;
  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] tail_value;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] remaining;
  logic [CNT_W-1:0] remaining_next;
  logic             strobe_next;
  result_t          result_next;
  logic             full;
  logic             empty;

  assign full  = cell_valid[CAPACITY-1];
  assign empty = !cell_valid[0];
  assign busy  = (remaining != '0);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] pv;
    logic signed [DATA_W-1:0] nv;
    logic                     pvld;
    logic                     nvld;
    if (i == 0) begin : g_first
      assign pv   = ctrl.push_value;
      assign pvld = 1'b1;
    end else begin : g_mid
      assign pv   = cell_value[i-1];
      assign pvld = cell_valid[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign nv   = '0;
      assign nvld = 1'b0;
    end else begin : g_inner
      assign nv   = cell_value[i+1];
      assign nvld = cell_valid[i+1];
    end
    assign cell_tail[i] = cell_valid[i] && !nvld;

    bdq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_value (pv),
      .prev_valid (pvld),
      .next_value (nv),
      .next_valid (nvld),
      .value      (cell_value[i]),
      .valid      (cell_valid[i])
    );
  end

  always_comb begin
    tail_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail_value = tail_value | (cell_value[i] & {DATA_W{cell_tail[i]}});
    end
  end

  always_comb begin
    ctrl.cmd         = CMD_HOLD;
    ctrl.push_value  = request.push_value;
    ctrl.head_value  = cell_value[0];
    count_next       = count;
    remaining_next   = remaining;
    strobe_next      = 1'b0;
    result_next.status      = ST_OK;
    result_next.data_value  = '0;
    result_next.last_result = 1'b1;
    if (busy) begin
      ctrl.cmd                = CMD_ROTATE;
      strobe_next             = 1'b1;
      result_next.data_value  = cell_value[0];
      result_next.last_result = (remaining == CNT_W'(1));
      remaining_next          = remaining - CNT_W'(1);
    end else if (start) begin
      case (request.operation)
        OP_PUSH_BACK, OP_PUSH_FRONT: begin
          strobe_next = 1'b1;
          if (full) begin
            result_next.status = ST_FULL;
          end else begin
            ctrl.cmd   = (request.operation == OP_PUSH_BACK) ? CMD_PUSH_BACK
                                                             : CMD_PUSH_FRONT;
            count_next = count + CNT_W'(1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          strobe_next = 1'b1;
          if (empty) begin
            result_next.status = ST_EMPTY;
          end else if (request.operation == OP_POP_FRONT) begin
            ctrl.cmd               = CMD_POP_FRONT;
            result_next.data_value = cell_value[0];
            count_next             = count - CNT_W'(1);
          end else begin
            ctrl.cmd               = CMD_POP_BACK;
            result_next.data_value = tail_value;
            count_next             = count - CNT_W'(1);
          end
        end
        OP_LIST: begin
          strobe_next = 1'b1;
          if (empty) begin
            result_next.status = ST_EMPTY;
          end else begin
            ctrl.cmd                = CMD_ROTATE;
            result_next.data_value  = cell_value[0];
            result_next.last_result = (count == CNT_W'(1));
            remaining_next          = count - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      count     <= '0;
      remaining <= '0;
      strobe    <= 1'b0;
    end else begin
      count     <= count_next;
      remaining <= remaining_next;
      strobe    <= strobe_next;
    end
  end

endmodule

/* rtl/bdq_cell.sv */
module bdq_cell
  import bdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctrl_t               ctrl,
  input  logic signed [DATA_W-1:0] prev_value,
  input  logic                     prev_valid,
  input  logic signed [DATA_W-1:0] next_value,
  input  logic                     next_valid,
  output logic signed [DATA_W-1:0] value,
  output logic                     valid
);

  logic signed [DATA_W-1:0] value_next;
  logic                     valid_next;
  logic                     is_tail;

  assign is_tail = valid && !next_valid;

  always_comb begin
    value_next = value;
    valid_next = valid;
    case (ctrl.cmd)
      CMD_PUSH_BACK: begin
        if (!valid && prev_valid) begin
          value_next = ctrl.push_value;
          valid_next = 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        value_next = prev_value;
        valid_next = prev_valid;
      end
      CMD_POP_FRONT: begin
        value_next = next_value;
        valid_next = next_valid;
      end
      CMD_POP_BACK: begin
        if (is_tail) begin
          valid_next = 1'b0;
        end
      end
      CMD_ROTATE: begin
        if (is_tail) begin
          value_next = ctrl.head_value;
        end else if (valid) begin
          value_next = next_value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule
